>>> rtl/sqoi_pkg.sv
// ----------------------------------------------------------------------------
// Squared overcurrent integrator package
// Shared widths, codes, reset values and structure types for the block.
// ----------------------------------------------------------------------------
package sqoi_pkg;

  localparam int BATCH      = 8;
  localparam int POS_W      = (BATCH > 1) ? $clog2(BATCH) : 1;
  localparam int SAMPLE_W   = 12;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int LIMIT_W    = 31;
  localparam int WINDOW_W   = 20;
  localparam int LEVEL_W    = 32;
  localparam int ELAPSED_W  = 21;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_SKIP    = 2'd1;
  localparam logic [1:0] MODE_DISCARD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 2'd2;

  localparam logic [SAMPLE_W-1:0] NOMINAL_LEVEL_RST  = 12'd75;
  localparam logic [LIMIT_W-1:0]  SUM_LIMIT_RST      = 31'd50000;
  localparam logic [WINDOW_W-1:0] WINDOW_SAMPLES_RST = 20'd2000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] nominal_level;
    logic [LIMIT_W-1:0]  sum_limit;
    logic [WINDOW_W-1:0] window_samples;
  } cfg_t;

  typedef struct packed {
    logic               trip;
    logic               window_restart;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

>>> rtl/sqoi_cfg.sv
// ----------------------------------------------------------------------------
// Squared overcurrent integrator configuration registers
// Holds the nominal level, the sum limit and the window length.
// ----------------------------------------------------------------------------
module sqoi_cfg
  import sqoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_level  <= NOMINAL_LEVEL_RST;
      cfg.sum_limit      <= SUM_LIMIT_RST;
      cfg.window_samples <= WINDOW_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOMINAL_LEVEL:  cfg.nominal_level  <= cfg_data[SAMPLE_W-1:0];
        CFG_SUM_LIMIT:      cfg.sum_limit      <= cfg_data[LIMIT_W-1:0];
        CFG_WINDOW_SAMPLES: cfg.window_samples <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sqoi_core.sv
// ----------------------------------------------------------------------------
// Squared overcurrent integrator core
// Batch sequencing, window timing and the saturating squared-excess sum.
// ----------------------------------------------------------------------------
module sqoi_core
  import sqoi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output result_t             result
);

  logic [LEVEL_W-1:0]   accumulated_sum, accumulated_sum_next;
  logic [ELAPSED_W-1:0] elapsed_samples, elapsed_samples_next;
  logic                 awake, awake_next;
  logic [POS_W-1:0]     batch_position, batch_position_next;
  logic [1:0]           batch_mode, batch_mode_next;

  logic                 start;
  logic                 last;
  logic [ELAPSED_W-1:0] elapsed_start;
  logic                 above;
  logic [SAMPLE_W-1:0]  diff;
  logic [SQ_W-1:0]      sq;
  logic [LEVEL_W:0]     sum_up;

  assign start         = (batch_position == '0);
  assign last          = (batch_position == POS_W'(BATCH - 1));
  assign elapsed_start = awake ? elapsed_samples : '0;
  assign above         = (sample >= cfg.nominal_level);
  assign diff          = above ? (sample - cfg.nominal_level) : (cfg.nominal_level - sample);
  assign sq            = SQ_W'(diff) * SQ_W'(diff);
  assign sum_up        = {1'b0, accumulated_sum} + (LEVEL_W + 1)'(sq);

  always_comb begin
    accumulated_sum_next  = accumulated_sum;
    elapsed_samples_next  = elapsed_samples;
    awake_next            = awake;
    batch_mode_next       = batch_mode;
    batch_position_next   = last ? '0 : batch_position + POS_W'(1);
    result.trip           = 1'b0;
    result.window_restart = 1'b0;

    if (start) begin
      batch_mode_next      = MODE_NORMAL;
      elapsed_samples_next = elapsed_start;
      awake_next           = 1'b1;
      if (elapsed_start >= ELAPSED_W'(cfg.window_samples)) begin
        awake_next           = 1'b0;
        elapsed_samples_next = '0;
        accumulated_sum_next = '0;
        batch_mode_next      = MODE_DISCARD;
      end
    end

    unique case (batch_mode_next)
      MODE_DISCARD: begin
        result.window_restart = 1'b1;
      end
      MODE_NORMAL: begin
        if (above) begin
          accumulated_sum_next = sum_up[LEVEL_W] ? {LEVEL_W{1'b1}} : sum_up[LEVEL_W-1:0];
        end else begin
          accumulated_sum_next = (accumulated_sum > LEVEL_W'(sq)) ?
                                 accumulated_sum - LEVEL_W'(sq) : '0;
        end
        if (accumulated_sum_next > LEVEL_W'(cfg.sum_limit)) begin
          result.trip     = 1'b1;
          batch_mode_next = MODE_SKIP;
        end
      end
      default: ;
    endcase

    if (last && batch_mode_next == MODE_NORMAL) begin
      if (elapsed_samples_next > ELAPSED_MAX - ELAPSED_W'(BATCH)) begin
        elapsed_samples_next = ELAPSED_MAX;
      end else begin
        elapsed_samples_next = elapsed_samples_next + ELAPSED_W'(BATCH);
      end
    end

    result.level = accumulated_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulated_sum <= '0;
      elapsed_samples <= '0;
      awake           <= 1'b0;
      batch_position  <= '0;
      batch_mode      <= MODE_NORMAL;
    end else if (step) begin
      accumulated_sum <= accumulated_sum_next;
      elapsed_samples <= elapsed_samples_next;
      awake           <= awake_next;
      batch_position  <= batch_position_next;
      batch_mode      <= batch_mode_next;
    end
  end

endmodule

>>> rtl/squared_overcurrent_integrator.sv
// ----------------------------------------------------------------------------
// Squared overcurrent integrator
// Adds the squared distance of current samples above a nominal level, takes
// it off for samples below, and flags a trip when the sum passes the limit.
//
// Usage: converter samples arrive as words on the input channel (in_valid,
// in_ready, sample); each gives exactly one result word on the output
// channel (out_valid, out_ready, trip, window_restart, level). Samples are
// taken in batches of eight for window timing. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. An accepted
// word is registered in the input register; its result is computed on the
// way to the output register and offered from there. Throughput is one word
// per cycle while the receiver keeps up, set by the combinational square, add
// and compare that updates the sum. When the receiver stalls, the output
// register holds its word; the input register takes at most one more word,
// and in_ready falls once it is full. Reset empties both registers, clears the
// sum, time count and batch position and restores the configuration defaults.
// ----------------------------------------------------------------------------
module squared_overcurrent_integrator
  import sqoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  trip,
  output logic                  window_restart,
  output logic [LEVEL_W-1:0]    level,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg;
  result_t             result;
  logic                held;
  logic [SAMPLE_W-1:0] held_sample;
  logic                advance;
  logic                step;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !held || advance;
  assign step     = advance && held;

  sqoi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sqoi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (held_sample),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        held <= in_valid;
      end
      if (advance) begin
        out_valid <= held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_sample <= sample;
    end
    if (step) begin
      trip           <= result.trip;
      window_restart <= result.window_restart;
      level          <= result.level;
    end
  end

`ifndef SYNTHESIS
  a_trip_restart_exclusive : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trip && window_restart))
    else $error("trip and window_restart raised together");

  a_restart_clears_level : assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_restart) |-> (level == '0))
    else $error("discarded word carries a non-zero level");

  a_trip_above_limit : assert property (@(posedge clk) disable iff (rst)
    (out_valid && trip) |-> (level > LEVEL_W'(cfg.sum_limit)))
    else $error("trip reported with level at or below the limit");

  a_stall_holds_input : assert property (@(posedge clk) disable iff (rst)
    (held && !advance) |=> (held && $stable(held_sample)))
    else $error("held word lost while the output stalled");
`endif

endmodule
